/* sv/assert_macros.svh */
// Assertion macros shared by the ready queue RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PRQ_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* sv/prq_pkg.sv */
// Package for the priority ready queue: field widths, codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prq_pkg;

  localparam int ID_FIELD_W    = 6;
  localparam int PRIO_W        = 8;
  localparam int STATUS_W      = 2;
  localparam int LEVEL_FIELD_W = 4;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_USED_W    = STATUS_W + 1 + ID_FIELD_W + LEVEL_FIELD_W;
  localparam int OUT_TDATA_W   = 16;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_COMMIT,
    S_SCAN,
    S_FRONT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    add_write;
    logic    search_read;
    logic    idx_inc;
    logic    shift_read;
    logic    shift_write;
    logic    remove_commit;
    logic    scan_dec;
    logic    scan_take;
    logic    front_read;
    logic    status_we;
    status_t status_val;
    logic    out_load;
  } prq_cmd_t;

  typedef struct packed {
    logic is_add;
    logic full;
    logic cnt_zero;
    logic match;
    logic idx_last;
    logic shift_last;
    logic empties_top;
    logic scan_hit;
    logic scan_zero;
    logic out_free;
  } prq_stat_t;

endpackage
`default_nettype wire

/* sv/prq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module prq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/prq_ctrl.sv */
// Controller state machine of the ready queue.
// Depends on prq_pkg; drives commands to prq_dpath and reads its status.
`timescale 1ns / 1ps
`default_nettype none
module prq_ctrl
  import prq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire prq_stat_t stat,
  output prq_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_add || stat.cnt_zero) begin
          state_next = S_FRONT;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_SRCH_RD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (stat.match) begin
          state_next = stat.idx_last ? S_COMMIT : S_SH_RD;
        end else if (stat.idx_last) begin
          state_next = S_FRONT;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_SH_RD: state_next = S_SH_WR;
      S_SH_WR: state_next = stat.shift_last ? S_COMMIT : S_SH_RD;
      S_COMMIT: state_next = stat.empties_top ? S_SCAN : S_FRONT;
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_zero) begin
          state_next = S_FRONT;
        end
      end
      S_FRONT: state_next = S_RESULT;
      S_RESULT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load       = 1'b1;
          cmd.status_we  = 1'b1;
          cmd.status_val = ST_DONE;
        end
      end
      S_DECODE: begin
        if (stat.is_add) begin
          if (stat.full) begin
            cmd.status_we  = 1'b1;
            cmd.status_val = ST_FULL;
          end else begin
            cmd.add_write = 1'b1;
          end
        end else if (stat.cnt_zero) begin
          cmd.status_we  = 1'b1;
          cmd.status_val = ST_NOT_FOUND;
        end
      end
      S_SRCH_RD: cmd.search_read = 1'b1;
      S_SRCH_CMP: begin
        if (!stat.match) begin
          if (stat.idx_last) begin
            cmd.status_we  = 1'b1;
            cmd.status_val = ST_NOT_FOUND;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_SH_RD: cmd.shift_read = 1'b1;
      S_SH_WR: begin
        cmd.shift_write = 1'b1;
        cmd.idx_inc     = 1'b1;
      end
      S_COMMIT: cmd.remove_commit = 1'b1;
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.scan_take = 1'b1;
        end else if (!stat.scan_zero) begin
          cmd.scan_dec = 1'b1;
        end
      end
      S_FRONT: cmd.front_read = 1'b1;
      S_RESULT: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* sv/prq_dpath.sv */
// Datapath of the ready queue: request registers, level counts, top level, entry RAM
// (prq_ram) and output register. Depends on prq_pkg, prq_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module prq_dpath
  import prq_pkg::*;
#(
  parameter int LEVELS       = 16,
  parameter int QUEUE_DEPTH  = 8,
  parameter int TASK_ID_BITS = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire prq_cmd_t               cmd,
  output prq_stat_t                   stat
);

  localparam int LVL_W     = $clog2(LEVELS);
  localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W     = CNT_W + 1;
  localparam int ADDR_W    = LVL_W + IDX_W;
  localparam int RAM_DEPTH = LEVELS * (1 << IDX_W);

  logic                    in_req;
  logic [ID_FIELD_W-1:0]   in_id;
  logic [PRIO_W-1:0]       in_prio;
  logic [TASK_ID_BITS+ID_FIELD_W-1:0] in_id_wide;
  logic [LVL_W-1:0]        in_lvl;

  logic                    req_op;
  logic [TASK_ID_BITS-1:0] id_q;
  logic [LVL_W-1:0]        lvl_q;
  logic [CNT_W-1:0]        n_q;
  logic [IDX_W-1:0]        idx;
  logic [LVL_W-1:0]        sl;
  logic [LVL_W-1:0]        top;
  status_t                 status_q;
  logic                    vld_q;
  logic [CNT_W-1:0]        counts [LEVELS];
  logic [LEVELS-1:0]       nonempty;

  logic [CMP_W-1:0]        idx_p1;
  logic [CMP_W-1:0]        idx_p2;
  logic [CMP_W-1:0]        n_ext;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [TASK_ID_BITS-1:0] ram_wdata;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [TASK_ID_BITS-1:0] rd_data;

  logic [TASK_ID_BITS-1:0] front_id;
  logic [TASK_ID_BITS+ID_FIELD_W-1:0]  nt_wide;
  logic [LVL_W+LEVEL_FIELD_W-1:0]      tl_wide;
  logic [OUT_USED_W-1:0]   out_word;

  assign in_req     = s_axis_tdata[0];
  assign in_id      = s_axis_tdata[ID_FIELD_W:1];
  assign in_prio    = s_axis_tdata[ID_FIELD_W+PRIO_W:ID_FIELD_W+1];
  assign in_id_wide = {{TASK_ID_BITS{1'b0}}, in_id};
  assign in_lvl     = (in_prio > PRIO_W'(LEVELS - 1)) ? LVL_W'(LEVELS - 1)
                                                      : in_prio[LVL_W-1:0];

  for (genvar g = 0; g < LEVELS; g++) begin : g_nonempty
    assign nonempty[g] = (counts[g] != '0);
  end

  assign idx_p1 = CMP_W'(idx) + CMP_W'(1);
  assign idx_p2 = CMP_W'(idx) + CMP_W'(2);
  assign n_ext  = CMP_W'(n_q);

  always_comb begin
    stat.is_add      = (req_op == REQ_ADD);
    stat.full        = (n_q >= CNT_W'(QUEUE_DEPTH));
    stat.cnt_zero    = (n_q == '0);
    stat.match       = (rd_data == id_q);
    stat.idx_last    = (idx_p1 >= n_ext);
    stat.shift_last  = (idx_p2 >= n_ext);
    stat.empties_top = (n_q == CNT_W'(1)) && (lvl_q == top);
    stat.scan_hit    = nonempty[sl];
    stat.scan_zero   = (sl == '0);
    stat.out_free    = !m_axis_tvalid || m_axis_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op <= in_req;
      id_q   <= in_id_wide[TASK_ID_BITS-1:0];
      lvl_q  <= in_lvl;
      n_q    <= counts[in_lvl];
      idx    <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.status_we) begin
      status_q <= cmd.status_val;
    end
    if (cmd.front_read) begin
      vld_q <= nonempty[top];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        counts[i] <= '0;
      end
      top <= '0;
      sl  <= '0;
    end else begin
      if (cmd.add_write) begin
        counts[lvl_q] <= n_q + CNT_W'(1);
        if (lvl_q > top) begin
          top <= lvl_q;
        end
      end
      if (cmd.remove_commit) begin
        counts[lvl_q] <= n_q - CNT_W'(1);
        sl            <= LVL_W'(LEVELS - 1);
        if (stat.empties_top) begin
          top <= '0;
        end
      end
      if (cmd.scan_dec) begin
        sl <= sl - LVL_W'(1);
      end
      if (cmd.scan_take) begin
        top <= sl;
      end
    end
  end

  assign ram_we    = cmd.add_write || cmd.shift_write;
  assign ram_waddr = cmd.add_write ? {lvl_q, n_q[IDX_W-1:0]} : {lvl_q, idx};
  assign ram_wdata = cmd.add_write ? id_q : rd_data;
  assign ram_re    = cmd.search_read || cmd.shift_read || cmd.front_read;

  always_comb begin
    if (cmd.front_read) begin
      ram_raddr = {top, {IDX_W{1'b0}}};
    end else if (cmd.shift_read) begin
      ram_raddr = {lvl_q, idx_p1[IDX_W-1:0]};
    end else begin
      ram_raddr = {lvl_q, idx};
    end
  end

  prq_ram #(
    .WIDTH  (TASK_ID_BITS),
    .DEPTH  (RAM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign front_id = vld_q ? rd_data : '0;
  assign nt_wide  = {{ID_FIELD_W{1'b0}}, front_id};
  assign tl_wide  = {{LEVEL_FIELD_W{1'b0}}, top};
  assign out_word = {tl_wide[LEVEL_FIELD_W-1:0], nt_wide[ID_FIELD_W-1:0], vld_q, status_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= OUT_TDATA_W'(out_word);
    end
  end

  `PRQ_ASSERT_NOW(a_add_not_full, clk, rst, cmd.add_write, !stat.full, "add written to a full level")
  `PRQ_ASSERT_NOW(a_commit_nonempty, clk, rst, cmd.remove_commit, !stat.cnt_zero, "remove on an empty level")
  `PRQ_ASSERT_NOW(a_scan_no_wrap, clk, rst, cmd.scan_dec, !stat.scan_zero, "level scan wrapped below zero")
  `PRQ_ASSERT_NEXT(a_out_loaded, clk, rst, cmd.out_load, m_axis_tvalid, "result word not presented")

endmodule
`default_nettype wire

/* sv/priority_preemptive_ready_queue_core.sv */
// Top level of the fixed-priority ready queue: controller plus datapath.
// Depends on prq_pkg, prq_ctrl, prq_dpath and prq_ram.
`timescale 1ns / 1ps
`default_nettype none
// Ready queue for a preemptive fixed-priority scheduler. Each input word adds
// or removes a task id at a priority level (clamped to LEVELS-1), and each one
// returns exactly one result word with a status and the current pick, the
// front task of the highest non-empty level. Words are handled one at a time
// by a controller that steps through a single entry RAM with one read and one
// write port. An add writes the id at the tail of its level unless that level
// is full. A remove reads and compares the entries of its level in order
// until it finds the id, then shifts the later entries down one place and
// commits the new count; when it empties the top level, a scan steps down the
// levels to find the new top. Only a level holding a single entry can be
// emptied. Each word ends by reading the front entry and waiting for the
// output register to free up. The next word is taken as soon as the result
// is in the output register, even if it is not yet read.
module priority_preemptive_ready_queue_core
  import prq_pkg::*;
#(
  parameter int LEVELS       = 16,
  parameter int QUEUE_DEPTH  = 8,
  parameter int TASK_ID_BITS = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // req_type[0], task_id[6:1], task_priority[14:7], zero[15]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // status[1:0], next_valid[2], next_task[8:3], top_level[12:9], zero[15:13]
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

  prq_cmd_t  cmd;
  prq_stat_t stat;

  prq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  prq_dpath #(
    .LEVELS       (LEVELS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
`default_nettype wire
